FILE: rtl/core/tbfw_pkg.sv
// ----------------------------------------------------------------------------
// tbfw_pkg
// Shared types, codes and buffer tables for the triple buffer frame writer.
// ----------------------------------------------------------------------------
package tbfw_pkg;

  localparam int unsigned ROW_LENGTH_DEF = 40;
  localparam int unsigned COL_W          = 6;
  localparam int unsigned PTR_W          = 8;
  localparam int unsigned BUF_W          = 2;

  localparam logic [7:0]       FRAME_END   = 8'hFF;
  localparam logic [PTR_W-1:0] ROW_FIRST   = 8'h08;
  localparam logic [BUF_W-1:0] NO_BUFFER   = 2'd3;
  localparam logic [BUF_W-1:0] LAST_BUFFER = 2'd2;

  // Register index, taken from paddr[2].
  localparam logic REG_BUF_EN = 1'b0;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_SYNC = 1'b1
  } op_e;

  typedef enum logic {
    ACT_VRAM   = 1'b0,
    ACT_ORIGIN = 1'b1
  } act_e;

  typedef struct packed {
    logic             valid;
    act_e             action;
    logic [PTR_W-1:0] row_ptr;
    logic [PTR_W-1:0] col_ptr;
    logic [7:0]       value;
  } result_t;

  function automatic logic [PTR_W-1:0] row_base(input logic [BUF_W-1:0] buf_idx);
    row_base = (buf_idx == 2'd2) ? 8'h20 : 8'h00;
  endfunction

  function automatic logic [PTR_W-1:0] col_base(input logic [BUF_W-1:0] buf_idx);
    col_base = (buf_idx == 2'd1) ? 8'hC0 : 8'h80;
  endfunction

  function automatic logic [7:0] origin_value(input logic [BUF_W-1:0] buf_idx);
    unique case (buf_idx)
      2'd1:    origin_value = 8'h48;
      2'd2:    origin_value = 8'h28;
      default: origin_value = 8'h08;
    endcase
  endfunction

endpackage

FILE: rtl/core/triple_buffer_frame_writer.sv
// ----------------------------------------------------------------------------
// triple_buffer_frame_writer
// Turns received bytes and sync samples into video controller writes.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle unless the input side stalls: the cursor
// and buffer state update in the cycle of the transfer and the result lands
// in a single output register in the cycle after. The input side stalls only
// while that register holds a result the sink has not taken. Ordinary bytes
// give video memory writes, a 0xFF byte closes the frame and gives nothing,
// and a falling sync edge with a buffer ready gives one display origin write.
module triple_buffer_frame_writer import tbfw_pkg::*; #(
  parameter int unsigned RowLength = ROW_LENGTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] byte_value, [8] vsync_level, [15:9] zero
  input  logic [15:0] s_axis_tdata,
  // [0] operation
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] row_pointer, [15:8] column_pointer, [23:16] write_value
  output logic [23:0] m_axis_tdata,
  // [0] action
  output logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic    buf_en_q;
  logic    cfg_wr;
  logic    s_xfer;
  result_t res;
  logic    out_valid_q;
  result_t out_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BUF_EN);
  assign prdata = (paddr[2] == REG_BUF_EN) ? {31'd0, buf_en_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_en_q <= 1'b1;
    end else if (cfg_wr) begin
      buf_en_q <= pwdata[0];
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  tbfw_core #(
    .RowLength(RowLength)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(s_xfer),
    .op_i    (op_e'(s_axis_tuser)),
    .byte_i  (s_axis_tdata[7:0]),
    .sync_i  (s_axis_tdata[8]),
    .buf_en_i(buf_en_q),
    .result_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_xfer && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.action;
  assign m_axis_tdata  = {out_q.value, out_q.col_ptr, out_q.row_ptr};

  // A frame end byte never leaves a result behind.
  a_frame_end_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && s_axis_tuser == OP_BYTE && s_axis_tdata[7:0] == FRAME_END)
      |=> !m_axis_tvalid)
    else $error("frame end byte produced a result");

  a_origin_ptrs_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ACT_ORIGIN) |-> (m_axis_tdata[15:0] == 16'd0))
    else $error("display origin result carries nonzero pointers");

  a_origin_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ACT_ORIGIN) |->
      (m_axis_tdata[23:16] == 8'h08 || m_axis_tdata[23:16] == 8'h48 ||
       m_axis_tdata[23:16] == 8'h28))
    else $error("display origin value outside the buffer table");

  a_vram_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ACT_VRAM) |->
      (m_axis_tdata[15] && m_axis_tdata[13:8] <= COL_W'(RowLength - 1)))
    else $error("video memory write column out of range");

endmodule

FILE: rtl/core/tbfw_core.sv
// ----------------------------------------------------------------------------
// tbfw_core
// Buffer rotation, cursor and sync edge state; forms the result of one item.
// ----------------------------------------------------------------------------
module tbfw_core import tbfw_pkg::*; #(
  parameter int unsigned RowLength = ROW_LENGTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  op_e        op_i,
  input  logic [7:0] byte_i,
  input  logic       sync_i,
  input  logic       buf_en_i,
  output result_t    result_o
);

  logic [BUF_W-1:0] in_buf_q, in_buf_d;
  logic [BUF_W-1:0] rdy_buf_q, rdy_buf_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [PTR_W-1:0] row_q, row_d;
  logic             prev_sync_q, prev_sync_d;

  logic             sync_fall;
  logic             row_end;

  assign sync_fall = prev_sync_q && !sync_i && (rdy_buf_q != NO_BUFFER);
  assign row_end   = (col_q >= COL_W'(RowLength - 1));

  always_comb begin
    in_buf_d    = in_buf_q;
    rdy_buf_d   = rdy_buf_q;
    col_d       = col_q;
    row_d       = row_q;
    prev_sync_d = prev_sync_q;
    result_o    = '0;

    if (op_i == OP_SYNC) begin
      prev_sync_d = sync_i;
      if (sync_fall) begin
        result_o.valid  = 1'b1;
        result_o.action = ACT_ORIGIN;
        result_o.value  = origin_value(rdy_buf_q);
        rdy_buf_d       = NO_BUFFER;
      end
    end else if (byte_i == FRAME_END) begin
      rdy_buf_d = in_buf_q;
      if (buf_en_i) begin
        in_buf_d = (in_buf_q >= LAST_BUFFER) ? '0 : in_buf_q + 2'd1;
      end
      col_d = '0;
      row_d = '0;
    end else begin
      result_o.valid   = 1'b1;
      result_o.action  = ACT_VRAM;
      result_o.row_ptr = row_base(in_buf_q) | row_q;
      result_o.col_ptr = col_base(in_buf_q) | PTR_W'(col_q);
      result_o.value   = byte_i;
      if (row_end) begin
        col_d = '0;
        // The first row is 0; the next rows continue from 8.
        row_d = (row_q == '0) ? ROW_FIRST : row_q + 8'd1;
      end else begin
        col_d = col_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_buf_q    <= '0;
      rdy_buf_q   <= NO_BUFFER;
      col_q       <= '0;
      row_q       <= '0;
      prev_sync_q <= 1'b0;
    end else if (accept_i) begin
      in_buf_q    <= in_buf_d;
      rdy_buf_q   <= rdy_buf_d;
      col_q       <= col_d;
      row_q       <= row_d;
      prev_sync_q <= prev_sync_d;
    end
  end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for triple_buffer_frame_writer: a scoreboard predicts
// the video memory and display origin writes for every byte and sync sample
// taken by the block, and compares them with the writes that leave it, under
// random idling on both stream sides and with both buffering settings.
// ----------------------------------------------------------------------------
module tb_top;
  import tbfw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [BUF_W-1:0] BUF_A = 2'd0;
  localparam logic [BUF_W-1:0] BUF_B = 2'd1;
  localparam logic [BUF_W-1:0] BUF_C = 2'd2;
  localparam logic [2:0] ADDR_BUF_EN = {REG_BUF_EN, 2'b00};
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 6;

  typedef struct packed {
    act_e             action;
    logic [PTR_W-1:0] row_ptr;
    logic [PTR_W-1:0] col_ptr;
    logic [7:0]       value;
  } vram_write_t;

  class vram_write_tracker;
    logic             buf_en = 1'b1;
    logic [BUF_W-1:0] in_buf = BUF_A;
    logic [BUF_W-1:0] rdy_buf = NO_BUFFER;
    logic [COL_W-1:0] col = '0;
    logic [PTR_W-1:0] row = '0;
    logic             prev_sync = 1'b0;
    vram_write_t      expected_writes[$];
    int               errors = 0;

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function logic [7:0] origin_of(logic [BUF_W-1:0] b);
      case (b)
        BUF_B:   return 8'h48;
        BUF_C:   return 8'h28;
        default: return 8'h08;
      endcase
    endfunction

    function void predict_writes(op_e op, logic [7:0] data, logic sync);
      vram_write_t w;
      logic [BUF_W-1:0] ib;
      ib = in_buf;
      if (op == OP_SYNC) begin
        if (prev_sync && !sync && rdy_buf != NO_BUFFER) begin
          w.action  = ACT_ORIGIN;
          w.row_ptr = '0;
          w.col_ptr = '0;
          w.value   = origin_of(rdy_buf);
          expected_writes.push_back(w);
          rdy_buf = NO_BUFFER;
        end
        prev_sync = sync;
      end else if (data == FRAME_END) begin
        rdy_buf = ib;
        if (buf_en) ib = (ib >= LAST_BUFFER) ? BUF_A : ib + 2'd1;
        in_buf = ib;
        col = '0;
        row = '0;
      end else begin
        w.action  = ACT_VRAM;
        w.row_ptr = ((ib == BUF_C) ? 8'h20 : 8'h00) | row;
        w.col_ptr = ((ib == BUF_B) ? 8'hC0 : 8'h80) | {2'b00, col};
        w.value   = data;
        expected_writes.push_back(w);
        // The first row sits at 0, the following ones start at 8.
        if (col >= COL_W'(ROW_LENGTH_DEF - 1)) begin
          col = '0;
          row = (row == '0) ? ROW_FIRST : row + 8'd1;
        end else begin
          col = col + 1'b1;
        end
      end
    endfunction

    task check_write(act_e action, logic [7:0] row_ptr, logic [7:0] col_ptr,
                     logic [7:0] value);
      vram_write_t w;
      if (expected_writes.size() == 0) begin
        report($sformatf("unexpected write act=%0d row=%h col=%h val=%h",
                         action, row_ptr, col_ptr, value));
        return;
      end
      w = expected_writes.pop_front();
      if (action !== w.action)
        report($sformatf("action %0d, expected %0d", action, w.action));
      if (row_ptr !== w.row_ptr)
        report($sformatf("row pointer %h, expected %h", row_ptr, w.row_ptr));
      if (col_ptr !== w.col_ptr)
        report($sformatf("column pointer %h, expected %h", col_ptr, w.col_ptr));
      if (value !== w.value)
        report($sformatf("write value %h, expected %h", value, w.value));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [7:0] byte_value, [8] vsync_level, [15:9] zero
  logic [15:0] s_axis_tdata = '0;
  // [0] operation
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] row_pointer, [15:8] column_pointer, [23:16] write_value
  logic [23:0] m_axis_tdata;
  // [0] action
  logic        m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  vram_write_tracker book = new();
  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 65;
  bit          hold_req = 1'b0;
  int unsigned stall_left = 0;

  always #2 clk_i = ~clk_i;

  triple_buffer_frame_writer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Sink side: checks each transfer and picks the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      book.check_write(act_e'(m_axis_tuser), m_axis_tdata[7:0], m_axis_tdata[15:8],
                       m_axis_tdata[23:16]);
    if (hold_req) begin
      hold_req = 1'b0;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(op_e op, logic [7:0] data, logic sync);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, sync, data};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    book.predict_writes(op, data, sync);
  endtask

  task automatic send_body_item();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) send_item(OP_BYTE, 8'($urandom_range(254)), 1'($urandom));
    else if (r < 97) send_item(OP_SYNC, 8'($urandom), 1'($urandom));
    else send_item(OP_BYTE, FRAME_END, 1'($urandom));
  endtask

  // Mostly whole frames with random content; a few are left open.
  task automatic random_frames(int unsigned budget);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(9) < 7) ? $urandom_range(50) : $urandom_range(130, 40);
      repeat (len) send_body_item();
      if ($urandom_range(9) != 0) send_item(OP_BYTE, FRAME_END, 1'($urandom));
      send_item(OP_SYNC, 8'($urandom), 1'b1);
      send_item(OP_SYNC, 8'($urandom), 1'b0);
      sent += len + 3;
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (book.expected_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_buffering(logic en);
    logic [31:0] rdata;
    wait_drained();
    apb_access(1'b1, ADDR_BUF_EN, {31'd0, en}, rdata);
    book.buf_en = en;
    apb_access(1'b0, ADDR_BUF_EN, '0, rdata);
    if (rdata[0] !== en)
      book.report($sformatf("buffering_enable reads %h, expected %0d", rdata, en));
  endtask

  initial begin
    logic [31:0] rdata;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_access(1'b0, ADDR_BUF_EN, '0, rdata);
    if (rdata[0] !== 1'b1)
      book.report($sformatf("buffering_enable resets to %h", rdata));

    // Directed: sync edge with nothing ready, writes before the first frame
    // end, byte items with the sync flag set, repeated sync levels, the display
    // origins of buffers A and C.
    send_item(OP_SYNC, 8'h00, 1'b1);
    send_item(OP_SYNC, 8'hFF, 1'b0);
    send_item(OP_BYTE, 8'h00, 1'b0);
    send_item(OP_BYTE, 8'hFE, 1'b1);
    send_item(OP_BYTE, 8'h55, 1'b0);
    send_item(OP_BYTE, FRAME_END, 1'b0);
    send_item(OP_BYTE, 8'hAA, 1'b1);
    send_item(OP_SYNC, 8'h00, 1'b1);
    send_item(OP_SYNC, 8'h00, 1'b1);
    send_item(OP_SYNC, 8'h00, 1'b0);
    send_item(OP_SYNC, 8'h00, 1'b0);
    send_item(OP_BYTE, FRAME_END, 1'b1);
    send_item(OP_BYTE, 8'h01, 1'b0);
    send_item(OP_BYTE, FRAME_END, 1'b0);
    send_item(OP_BYTE, 8'h80, 1'b0);
    send_item(OP_SYNC, 8'h7F, 1'b1);
    send_item(OP_SYNC, 8'h7F, 1'b0);
    send_item(OP_BYTE, FRAME_END, 1'b0);
    send_item(OP_SYNC, 8'h00, 1'b1);
    send_item(OP_SYNC, 8'h00, 1'b0);

    // With buffering off the frame end keeps the current buffer.
    set_buffering(1'b0);
    hold_req = 1'b1;
    random_frames(120);

    set_buffering(1'b1);
    send_idle_pct = 65;
    recv_idle_pct = 12;
    random_frames(120);

    set_buffering(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_frames(120);

    set_buffering(1'b1);
    random_frames(120);

    wait_drained();
    if (book.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
